// ===== design/h264kf_pkg.sv =====
package h264kf_pkg;

   localparam int DEFAULT_SIZE_FIELD_BITS = 16;
   localparam int SIZE_WORD_BITS = 16;

   localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
   localparam logic [4:0] NAL_TYPE_STAP_A = 5'd24;
   localparam logic [4:0] NAL_TYPE_FU_A = 5'd28;
   localparam logic [4:0] NAL_TYPE_FU_B = 5'd29;
   localparam int FU_START_BIT = 7;

   localparam logic [2:0] TARGET_LAYER_RESET = 3'd7;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       first_byte;
      logic       last_byte;
      logic       marking_present;
      logic       mark_start;
      logic       mark_independent;
      logic       mark_base;
      logic [2:0] mark_layer;
   } req_item_type;

   typedef struct packed {
      logic       descriptor_valid;
      logic       key_frame;
      logic       forward;
      logic [2:0] layer_now;
   } rsp_item_type;

   typedef enum logic [1:0] {
      WALK_SIZE_HIGH,
      WALK_SIZE_LOW,
      WALK_TYPE,
      WALK_SKIP
   } walk_phase_type;

   typedef struct packed {
      logic restart;
      logic step;
   } walk_ctl_type;

   typedef struct packed {
      logic       update;
      logic       has_tid;
      logic       base;
      logic [2:0] tid;
   } layer_ctl_type;

endpackage

// ===== design/h264_rtp_keyframe_and_layer_filter.sv =====
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall req_item (one payload byte and its flags)
// rsp       out        rsp_valid/rsp_stall rsp_item (one result per payload)
// csr       in         csr_write_enable    csr_write_data (target layer)
//
// One byte is taken every cycle while req_stall is low; the per-byte parse sits between
// the input register and the result register, from which each result is offered.
// Reset is synchronous; it empties both registers, closes any open payload, sets the
// current layer to 0 and the target layer to 7.
// A stalled result holds in the result register; the input register keeps taking bytes
// that give no result, and req_stall rises only when a last byte waits behind it.
module h264_rtp_keyframe_and_layer_filter #(
   parameter int SIZE_FIELD_BITS = h264kf_pkg::DEFAULT_SIZE_FIELD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  h264kf_pkg::req_item_type req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output h264kf_pkg::rsp_item_type rsp_item,
   input  logic                     csr_write_enable,
   input  logic [2:0]               csr_write_data
);
   import h264kf_pkg::*;

   req_item_type  req_item_ff;
   logic          req_valid_ff, req_valid_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    target_layer_ff;

   logic [1:0]    position_ff, position_in;
   logic [4:0]    nal_kind_ff, nal_kind_in;
   logic          walk_active_ff, walk_active_in;
   logic          key_seen_ff, key_seen_in;
   logic          held_present_ff, held_present_in;
   logic          held_base_ff, held_base_in;
   logic [2:0]    held_layer_ff, held_layer_in;

   logic          req_accept;
   logic          live;
   logic          gives_result;
   logic          advance;
   logic          proc;
   logic [1:0]    index;
   logic          fu_hit;
   logic          walk_hit;
   walk_ctl_type  walk_ctl;
   layer_ctl_type layer_ctl;
   logic          layer_forward;
   logic [2:0]    layer_next;
   logic [2:0]    layer_now;

   assign live = req_item_ff.first_byte || (position_ff != 2'd0);
   assign gives_result = live && req_item_ff.last_byte;
   assign advance = req_valid_ff && (!rsp_valid_ff || !rsp_stall || !gives_result);
   assign proc = advance && live;
   assign req_stall = req_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign index = req_item_ff.first_byte ? 2'd0 : position_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_layer_ff <= TARGET_LAYER_RESET;
         position_ff <= '0;
         nal_kind_ff <= '0;
         walk_active_ff <= 1'b0;
         key_seen_ff <= 1'b0;
         held_present_ff <= 1'b0;
         held_base_ff <= 1'b0;
         held_layer_ff <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            target_layer_ff <= csr_write_data;
         end
         position_ff <= position_in;
         nal_kind_ff <= nal_kind_in;
         walk_active_ff <= walk_active_in;
         key_seen_ff <= key_seen_in;
         held_present_ff <= held_present_in;
         held_base_ff <= held_base_in;
         held_layer_ff <= held_layer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_item_ff <= req_item;
      end
      if (proc && req_item_ff.last_byte) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign walk_ctl.restart = proc && req_item_ff.first_byte;
   assign walk_ctl.step = proc && !req_item_ff.first_byte && walk_active_ff;

   h264kf_walk #(
      .SIZE_FIELD_BITS(SIZE_FIELD_BITS)
   ) u_walk (
      .clock(clock),
      .reset(reset),
      .ctl(walk_ctl),
      .payload_byte(req_item_ff.payload_byte),
      .key_hit(walk_hit)
   );

   assign layer_ctl.update = proc && req_item_ff.last_byte && (index != 2'd0);
   assign layer_ctl.has_tid = held_present_ff;
   assign layer_ctl.base = held_base_ff;
   assign layer_ctl.tid = held_layer_ff;

   h264kf_layer u_layer (
      .clock(clock),
      .reset(reset),
      .ctl(layer_ctl),
      .target_layer(target_layer_ff),
      .forward(layer_forward),
      .layer_next(layer_next),
      .layer_now(layer_now)
   );

   assign fu_hit = (index == 2'd1) && (nal_kind_ff inside {NAL_TYPE_FU_A, NAL_TYPE_FU_B})
                   && (req_item_ff.payload_byte[4:0] == NAL_TYPE_SPS)
                   && req_item_ff.payload_byte[FU_START_BIT];

   always_comb begin
      req_valid_in = req_accept || (req_valid_ff && !advance);
      rsp_valid_in = (proc && req_item_ff.last_byte) || (rsp_valid_ff && rsp_stall);

      position_in = position_ff;
      nal_kind_in = nal_kind_ff;
      walk_active_in = walk_active_ff;
      key_seen_in = key_seen_ff;
      held_present_in = held_present_ff;
      held_base_in = held_base_ff;
      held_layer_in = held_layer_ff;

      if (proc) begin
         if (req_item_ff.first_byte) begin
            nal_kind_in = req_item_ff.payload_byte[4:0];
            key_seen_in = (req_item_ff.marking_present && req_item_ff.mark_start
                           && req_item_ff.mark_independent)
                          || (req_item_ff.payload_byte[4:0] == NAL_TYPE_SPS);
            walk_active_in = (req_item_ff.payload_byte[4:0] == NAL_TYPE_STAP_A);
            held_present_in = req_item_ff.marking_present;
            held_base_in = req_item_ff.mark_base;
            held_layer_in = req_item_ff.mark_layer;
         end else begin
            key_seen_in = key_seen_ff || fu_hit || walk_hit;
         end
         position_in = (index == 2'd3) ? 2'd3 : index + 2'd1;
         if (req_item_ff.last_byte) begin
            position_in = 2'd0;
            walk_active_in = 1'b0;
         end
      end

      rsp_item_in.descriptor_valid = (index != 2'd0);
      rsp_item_in.key_frame = (index != 2'd0) && key_seen_in;
      rsp_item_in.forward = (index != 2'd0) && layer_forward;
      rsp_item_in.layer_now = (index != 2'd0) ? layer_next : layer_now;
   end

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> (req_valid_ff && $stable(req_item_ff)))
      else $error("input register lost or changed a waiting item");

   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && gives_result))
      else $error("input stalled without a blocked result");

   a_payload_closed: assert property (@(posedge clock) disable iff (reset)
      (proc && req_item_ff.last_byte) |=> (position_ff == 2'd0 && !walk_active_ff))
      else $error("payload still open after its last byte");

   a_short_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.descriptor_valid)
      |-> (!rsp_item_ff.key_frame && !rsp_item_ff.forward && rsp_item_ff.layer_now == layer_now))
      else $error("short payload result carries a key or forward flag");

endmodule

// ===== design/h264kf_walk.sv =====
module h264kf_walk #(
   parameter int SIZE_FIELD_BITS = h264kf_pkg::DEFAULT_SIZE_FIELD_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  h264kf_pkg::walk_ctl_type ctl,
   input  logic [7:0]              payload_byte,
   output logic                    key_hit
);
   import h264kf_pkg::*;

   walk_phase_type              phase_ff, phase_in;
   logic [SIZE_FIELD_BITS-1:0]  countdown_ff, countdown_in;
   logic [SIZE_FIELD_BITS-1:0]  countdown_dec;
   logic [7:0]                  size_high_ff, size_high_in;
   logic [SIZE_WORD_BITS-1:0]   size_word;

   assign size_word = {size_high_ff, payload_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= WALK_SIZE_HIGH;
         countdown_ff <= '0;
         size_high_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         countdown_ff <= countdown_in;
         size_high_ff <= size_high_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      countdown_in = countdown_ff;
      size_high_in = size_high_ff;
      key_hit = 1'b0;
      countdown_dec = (countdown_ff != '0) ? countdown_ff - SIZE_FIELD_BITS'(1) : countdown_ff;
      if (ctl.restart) begin
         phase_in = WALK_SIZE_HIGH;
         countdown_in = '0;
         size_high_in = '0;
      end else if (ctl.step) begin
         case (phase_ff)
            WALK_SIZE_HIGH: begin
               size_high_in = payload_byte;
               phase_in = WALK_SIZE_LOW;
            end
            WALK_SIZE_LOW: begin
               countdown_in = size_word[SIZE_FIELD_BITS-1:0];
               phase_in = WALK_TYPE;
            end
            WALK_TYPE: begin
               key_hit = (payload_byte[4:0] == NAL_TYPE_SPS);
               if (countdown_ff == '0) begin
                  // An empty unit: its type byte is also the next size's high byte.
                  size_high_in = payload_byte;
                  phase_in = WALK_SIZE_LOW;
               end else begin
                  countdown_in = countdown_dec;
                  phase_in = (countdown_dec == '0) ? WALK_SIZE_HIGH : WALK_SKIP;
               end
            end
            WALK_SKIP: begin
               countdown_in = countdown_dec;
               if (countdown_dec == '0) begin
                  phase_in = WALK_SIZE_HIGH;
               end
            end
            default: begin
               phase_in = WALK_SIZE_HIGH;
            end
         endcase
      end
   end

endmodule

// ===== design/h264kf_layer.sv =====
module h264kf_layer (
   input  logic                      clock,
   input  logic                      reset,
   input  h264kf_pkg::layer_ctl_type ctl,
   input  logic [2:0]                target_layer,
   output logic                      forward,
   output logic [2:0]                layer_next,
   output logic [2:0]                layer_now
);
   import h264kf_pkg::*;

   logic [2:0] layer_ff, layer_in;
   logic [2:0] raised;

   assign layer_now = layer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_ff <= '0;
      end else begin
         layer_ff <= layer_in;
      end
   end

   always_comb begin
      forward = 1'b1;
      layer_next = layer_ff;
      raised = 3'd0;
      if (ctl.has_tid && (ctl.tid > target_layer)) begin
         forward = 1'b0;
      end else if (ctl.has_tid && (ctl.tid > layer_ff) && !ctl.base) begin
         forward = 1'b0;
      end else begin
         if (ctl.has_tid) begin
            raised = (ctl.tid > layer_ff) ? ctl.tid : layer_ff;
         end
         layer_next = (raised > target_layer) ? target_layer : raised;
      end
      layer_in = ctl.update ? layer_next : layer_ff;
   end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
   import h264kf_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int SIZE_BITS = DEFAULT_SIZE_FIELD_BITS;
   localparam logic [15:0] SIZE_MASK = 16'((32'd1 << SIZE_BITS) - 32'd1);
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_ITEMS = 200;
   localparam int PHASE_COUNT = 5;
   localparam int TIMEOUT_CYCLES = 200000;

   typedef enum int {
      PACE_FREE,
      PACE_LIGHT,
      PACE_HEAVY,
      PACE_PERIODIC
   } pace_mode_type;

   typedef struct packed {
      req_item_type item;
      logic         fixed_want;
      rsp_item_type want;
   } probe_row_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_write_enable = 1'b0;
   logic [2:0]   csr_write_data = '0;

   h264_rtp_keyframe_and_layer_filter #(
      .SIZE_FIELD_BITS(SIZE_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item        (rsp_item),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   // Tracked copy of the filter state.
   logic [1:0]     trk_pos = '0;
   logic [4:0]     trk_nal = '0;
   logic [16:0]    trk_count = '0;
   logic [7:0]     trk_size_high = '0;
   logic           trk_walking = 1'b0;
   walk_phase_type trk_phase = WALK_SIZE_HIGH;
   logic           trk_key = 1'b0;
   logic           trk_has_tid = 1'b0;
   logic           trk_base = 1'b0;
   logic [2:0]     trk_tid = '0;
   logic [2:0]     trk_layer = '0;
   logic [2:0]     trk_target = TARGET_LAYER_RESET;

   rsp_item_type  due_results[$];
   probe_row_type probe_rows[$];
   int            fail_count = 0;
   int            burst_left = 0;
   bit            idle_on = 1'b1;
   bit            hold_wanted = 1'b0;
   bit            hold_active = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("testbench: errors");
      $finish;
   end

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   function automatic bit track_payload_byte(input req_item_type it, output rsp_item_type res);
      int         pos;
      logic [7:0] b;
      bit         fwd;
      b = it.payload_byte;
      res = '0;
      if (it.first_byte) begin
         trk_has_tid = it.marking_present;
         trk_base = it.mark_base;
         trk_tid = it.mark_layer;
         trk_nal = b[4:0];
         trk_key = (it.marking_present && it.mark_start && it.mark_independent)
                   || trk_nal == NAL_TYPE_SPS;
         trk_walking = (trk_nal == NAL_TYPE_STAP_A);
         trk_phase = WALK_SIZE_HIGH;
         trk_count = '0;
         trk_size_high = '0;
         pos = 0;
      end else begin
         if (trk_pos == 2'd0) begin
            return 1'b0;
         end
         pos = trk_pos;
         if (pos == 1 && (trk_nal == NAL_TYPE_FU_A || trk_nal == NAL_TYPE_FU_B)
             && b[4:0] == NAL_TYPE_SPS && b[FU_START_BIT]) begin
            trk_key = 1'b1;
         end
         if (trk_walking) begin
            case (trk_phase)
               WALK_SIZE_HIGH: begin
                  trk_size_high = b;
                  trk_phase = WALK_SIZE_LOW;
               end
               WALK_SIZE_LOW: begin
                  trk_count = {1'b0, {trk_size_high, b} & SIZE_MASK};
                  trk_phase = WALK_TYPE;
               end
               WALK_TYPE: begin
                  if (b[4:0] == NAL_TYPE_SPS) begin
                     trk_key = 1'b1;
                  end
                  if (trk_count == 0) begin
                     trk_size_high = b;
                     trk_phase = WALK_SIZE_LOW;
                  end else begin
                     trk_count = trk_count - 17'd1;
                     trk_phase = (trk_count == 0) ? WALK_SIZE_HIGH : WALK_SKIP;
                  end
               end
               default: begin
                  if (trk_count > 0) begin
                     trk_count = trk_count - 17'd1;
                  end
                  if (trk_count == 0) begin
                     trk_phase = WALK_SIZE_HIGH;
                  end
               end
            endcase
         end
      end
      trk_pos = (pos >= 3) ? 2'd3 : 2'(pos + 1);
      if (!it.last_byte) begin
         return 1'b0;
      end
      trk_pos = '0;
      trk_walking = 1'b0;
      if (pos == 0) begin
         res = {1'b0, 1'b0, 1'b0, trk_layer};
         return 1'b1;
      end
      fwd = 1'b1;
      if (trk_has_tid && trk_tid > trk_target) begin
         fwd = 1'b0;
      end else if (trk_has_tid && trk_tid > trk_layer && !trk_base) begin
         fwd = 1'b0;
      end else begin
         if (trk_has_tid && trk_tid > trk_layer) begin
            trk_layer = trk_tid;
         end else if (!trk_has_tid) begin
            trk_layer = '0;
         end
         if (trk_layer > trk_target) begin
            trk_layer = trk_target;
         end
      end
      res = {1'b1, trk_key, fwd, trk_layer};
      return 1'b1;
   endfunction

   task automatic offer_byte(input req_item_type it, input logic fixed_want,
                             input rsp_item_type want);
      rsp_item_type res;
      if (idle_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_item <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end
      if (track_payload_byte(it, res)) begin
         due_results.push_back(fixed_want ? want : res);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (due_results.size() == 0) begin
            note_failure($sformatf("unexpected result %b", rsp_item));
         end else begin
            want = due_results.pop_front();
            if (rsp_item.descriptor_valid !== want.descriptor_valid
                || rsp_item.key_frame !== want.key_frame
                || rsp_item.forward !== want.forward
                || rsp_item.layer_now !== want.layer_now) begin
               note_failure($sformatf(
                  "mismatch: want %b %b %b %0d, got %b %b %b %0d (valid key fwd layer)",
                  want.descriptor_valid, want.key_frame, want.forward, want.layer_now,
                  rsp_item.descriptor_valid, rsp_item.key_frame, rsp_item.forward,
                  rsp_item.layer_now));
            end
         end
      end
   end

   initial begin : rsp_pacing
      pace_mode_type mode;
      int unsigned   span;
      int unsigned   tick;
      tick = 0;
      forever begin
         mode = pace_mode_type'($urandom_range(0, 3));
         span = $urandom_range(16, 160);
         repeat (span) begin
            @(posedge clock);
            tick++;
            case (mode)
               PACE_FREE: rsp_stall <= 1'b0;
               PACE_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               PACE_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 1);
               default: rsp_stall <= (tick % 7 < 3);
            endcase
         end
         if (hold_wanted) begin
            @(posedge clock);
            rsp_stall <= 1'b1;
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_active = 1'b0;
            hold_wanted = 1'b0;
         end
      end
   end

   initial begin : stimulus
      req_item_type pkt[$];
      logic [7:0]   body[$];
      logic [7:0]   hdr;
      logic [4:0]   nal;
      logic [6:0]   mk;
      logic [15:0]  usize;
      logic [2:0]   lvl;
      bit           close;
      int           len;
      int           roll;
      int           sent;
      int           k;

      // Columns: byte, first, last, {present, start, independent, base, layer},
      // fixed expectation flag, {valid, key, forward, layer}.
      probe_rows.push_back({8'h00, 1'b1, 1'b1, 7'h00, 1'b1, 6'b000_000});
      probe_rows.push_back({8'hFF, 1'b0, 1'b1, 7'h7F, 1'b0, 6'b000_000});
      probe_rows.push_back({8'h67, 1'b1, 1'b0, 7'h00, 1'b0, 6'b000_000});
      probe_rows.push_back({8'h00, 1'b0, 1'b1, 7'h00, 1'b1, 6'b111_000});
      probe_rows.push_back({8'h01, 1'b1, 1'b0, 7'h7F, 1'b0, 6'b000_000});
      probe_rows.push_back({8'hFF, 1'b0, 1'b1, 7'h00, 1'b1, 6'b111_111});
      probe_rows.push_back({8'hFF, 1'b1, 1'b1, 7'h00, 1'b1, 6'b000_111});
      probe_rows.push_back({8'h7C, 1'b1, 1'b0, 7'h00, 1'b0, 6'b000_000});
      probe_rows.push_back({8'h87, 1'b0, 1'b0, 7'h00, 1'b0, 6'b000_000});
      probe_rows.push_back({8'h00, 1'b0, 1'b1, 7'h00, 1'b0, 6'b000_000});
      probe_rows.push_back({8'h1D, 1'b1, 1'b0, 7'h43, 1'b0, 6'b000_000});
      probe_rows.push_back({8'h07, 1'b0, 1'b1, 7'h00, 1'b0, 6'b000_000});
      probe_rows.push_back({8'h18, 1'b1, 1'b0, 7'h4A, 1'b0, 6'b000_000});
      probe_rows.push_back({8'h00, 1'b0, 1'b0, 7'h00, 1'b0, 6'b000_000});
      probe_rows.push_back({8'h00, 1'b0, 1'b0, 7'h00, 1'b0, 6'b000_000});
      probe_rows.push_back({8'hFF, 1'b0, 1'b0, 7'h00, 1'b0, 6'b000_000});
      probe_rows.push_back({8'hFF, 1'b0, 1'b0, 7'h00, 1'b0, 6'b000_000});
      probe_rows.push_back({8'h07, 1'b0, 1'b1, 7'h00, 1'b0, 6'b000_000});
      probe_rows.push_back({8'h05, 1'b1, 1'b0, 7'h00, 1'b0, 6'b000_000});
      probe_rows.push_back({8'h67, 1'b1, 1'b0, 7'h70, 1'b0, 6'b000_000});
      probe_rows.push_back({8'h00, 1'b0, 1'b1, 7'h00, 1'b0, 6'b000_000});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_rows[n]) begin
         offer_byte(probe_rows[n].item, probe_rows[n].fixed_want, probe_rows[n].want);
      end

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         settle();
         case (ph)
            0: lvl = 3'd0;
            1: lvl = 3'd7;
            2: lvl = 3'($urandom_range(1, 6));
            3: lvl = 3'd3;
            default: lvl = 3'($urandom_range(0, 7));
         endcase
         csr_write_data <= lvl;
         csr_write_enable <= 1'b1;
         @(posedge clock);
         csr_write_enable <= 1'b0;
         trk_target = lvl;
         idle_on = (ph != 2);
         burst_left = 0;
         if (ph == 1) begin
            hold_wanted = 1'b1;
            wait (hold_active);
         end

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pkt.delete();
            body.delete();
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
               len = 1;
            end else if (roll < 16) begin
               len = $urandom_range(2, 8);
            end else if (roll < 19) begin
               len = $urandom_range(9, 24);
            end else begin
               len = $urandom_range(25, 60);
            end
            case ($urandom_range(0, 5))
               0: nal = NAL_TYPE_SPS;
               1, 2: nal = NAL_TYPE_STAP_A;
               3: nal = NAL_TYPE_FU_A;
               4: nal = NAL_TYPE_FU_B;
               default: nal = 5'($urandom);
            endcase
            hdr = {3'($urandom), nal};
            mk = 7'($urandom);
            close = ($urandom_range(0, 11) != 0);

            if (nal == NAL_TYPE_STAP_A) begin
               while (body.size() < len - 1) begin
                  if ($urandom_range(0, 9) == 0) begin
                     usize = 16'($urandom);
                  end else begin
                     usize = 16'($urandom_range(0, 4));
                  end
                  body.push_back(usize[15:8]);
                  body.push_back(usize[7:0]);
                  if (usize != 0) begin
                     body.push_back(($urandom_range(0, 2) == 0) ?
                                    {3'($urandom), NAL_TYPE_SPS} : 8'($urandom));
                     for (k = 1; k < usize && body.size() < len - 1; k++) begin
                        body.push_back(8'($urandom));
                     end
                  end
               end
            end else if (nal == NAL_TYPE_FU_A || nal == NAL_TYPE_FU_B) begin
               body.push_back({1'($urandom), 2'($urandom),
                               ($urandom_range(0, 1) == 1) ? NAL_TYPE_SPS : 5'($urandom)});
            end
            while (body.size() < len - 1) begin
               body.push_back(8'($urandom));
            end

            if ($urandom_range(0, 15) == 0) begin
               pkt.push_back({8'($urandom), 1'b0, 1'($urandom), 7'($urandom)});
            end
            pkt.push_back({hdr, 1'b1, (len == 1) && close, mk});
            for (k = 0; k < len - 1; k++) begin
               pkt.push_back({body[k], 1'b0, (k == len - 2) && close, 7'($urandom)});
            end

            foreach (pkt[n]) begin
               offer_byte(pkt[n], 1'b0, '0);
            end
            sent += len;
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule

// ===== h264_rtp_keyframe_and_layer_filter.f =====
design/h264kf_pkg.sv
design/h264kf_walk.sv
design/h264kf_layer.sv
design/h264_rtp_keyframe_and_layer_filter.sv
tb/sv/testbench.sv
